/* rtl/core/crss_pkg.sv */
`timescale 1ns / 1ps
package crss_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int SUM_WIDTH   = 48;
  localparam int WSUM_WIDTH  = 64;
  localparam int EXP_WIDTH   = 32;
  localparam int SLOPE_WIDTH = 32;
  localparam int TERMS       = 12;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  // floor(2^32 / k) for the taylor divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] r;
    unique case (k)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'h0_8000_0000;
      4'd3:    r = 33'h0_5555_5555;
      4'd4:    r = 33'h0_4000_0000;
      4'd5:    r = 33'h0_3333_3333;
      4'd6:    r = 33'h0_2AAA_AAAA;
      4'd7:    r = 33'h0_2492_4924;
      4'd8:    r = 33'h0_2000_0000;
      4'd9:    r = 33'h0_1C71_C71C;
      4'd10:   r = 33'h0_1999_9999;
      4'd11:   r = 33'h0_1745_D174;
      4'd12:   r = 33'h0_1555_5555;
      default: r = 33'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/cox_risk_set_slope.sv */
`timescale 1ns / 1ps
// an item runs from S_IDLE to S_OUT; when the exponential saturates or underflows the taylor steps are skipped
// a group end adds 64 quotient steps and the slope step (only the slope step when the exp sum is zero)
// one item at a time: the next item is taken only in S_IDLE, after the result of the last one is registered
// the shared 33x34 multiplier is used in turn: three exp set-up products, three per taylor term
// over 12 terms, then the weighted product; receiver hold-off stalls the result in S_OUT
// synchronous active-low reset clears beta, the sums, the slope and the handshakes
module cox_risk_set_slope import crss_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // member_value, event_value
  input  logic         in_tlast,   // group_end
  input  logic         in_tuser,   // slots_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // member_exp, partition_sum, weighted_mean, slope_total
  output logic         out_tlast,  // group_done
  output logic         out_tuser   // slope_done
);

  typedef enum logic [4:0] {
    S_IDLE, S_BX, S_LOG, S_SPLIT, S_G, S_GSH, S_TMUL, S_TREC, S_TQK, S_TFIX,
    S_SHIFT, S_WMUL, S_ACC, S_DIV, S_SLOPE, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VALUE_WIDTH-1:0] beta_r, x_r, ev_r;
  logic                          gend_r, send_r;
  logic signed [66:0]            prod_r;
  logic signed [32:0]            mul_a;
  logic signed [33:0]            mul_b;
  logic signed [7:0]             n_r;
  logic [23:0]                   f_r;
  logic [29:0]                   g_r;
  logic [30:0]                   term_r, a_r, q_r;
  logic [31:0]                   sum_r;
  logic [3:0]                    k_r;
  logic [EXP_WIDTH-1:0]          e_r;
  logic [SUM_WIDTH-1:0]          esum_r;
  logic signed [WSUM_WIDTH-1:0]  wsum_r;
  logic signed [SLOPE_WIDTH-1:0] slope_r;
  logic [WSUM_WIDTH-1:0]         dvd_r;
  logic [SUM_WIDTH:0]            rem_r;
  logic [5:0]                    cnt_r;
  logic                          neg_r;
  logic signed [VALUE_WIDTH-1:0] mean_r;
  logic                          out_valid_r;
  logic [127:0]                  out_data_r;
  logic                          out_last_r, out_user_r;

  logic [SUM_WIDTH:0]            es_add;
  logic signed [WSUM_WIDTH:0]    ws_add;
  logic [SUM_WIDTH-1:0]          es_new;
  logic signed [WSUM_WIDTH-1:0]  ws_new;
  logic [SUM_WIDTH:0]            rem_sh;
  logic [34:0]                   trem;
  logic [30:0]                   tq;
  logic [7:0]                    sh8;
  logic signed [VALUE_WIDTH-1:0] mean_c;
  logic signed [VALUE_WIDTH-1:0] mean_use;
  logic signed [SLOPE_WIDTH+1:0] d_c;
  logic                          d_c_sat_hi, d_c_sat_lo;
  logic                          out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_BX: begin
        mul_a = 33'(beta_r);
        mul_b = 34'(x_r);
      end
      S_LOG: begin
        mul_a = 33'(signed'(prod_r[31:0]));
        mul_b = 34'({1'b0, LOG2E_Q30});
      end
      S_G: begin
        mul_a = 33'({1'b0, f_r});
        mul_b = 34'({1'b0, LN2_Q30});
      end
      S_TMUL: begin
        mul_a = 33'({1'b0, term_r});
        mul_b = 34'({1'b0, g_r});
      end
      S_TREC: begin
        mul_a = 33'({1'b0, prod_r[60:30]});
        mul_b = signed'({1'b0, recip(k_r)});
      end
      S_TQK: begin
        mul_a = 33'({1'b0, prod_r[62:32]});
        mul_b = 34'({1'b0, k_r});
      end
      S_WMUL: begin
        mul_a = signed'({1'b0, e_r});
        mul_b = 34'(x_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    es_add = {1'b0, esum_r} + {17'd0, e_r};
    es_new = es_add[SUM_WIDTH] ? SUM_MAX : es_add[SUM_WIDTH-1:0];
    ws_add = {wsum_r[WSUM_WIDTH-1], wsum_r} + {prod_r[WSUM_WIDTH-1], prod_r[WSUM_WIDTH-1:0]};
    if (ws_add[WSUM_WIDTH] != ws_add[WSUM_WIDTH-1]) begin
      ws_new = ws_add[WSUM_WIDTH] ? {1'b1, {(WSUM_WIDTH-1){1'b0}}}
                                  : {1'b0, {(WSUM_WIDTH-1){1'b1}}};
    end else begin
      ws_new = ws_add[WSUM_WIDTH-1:0];
    end
    rem_sh = {rem_r[SUM_WIDTH-1:0], dvd_r[WSUM_WIDTH-1]};
    trem   = {4'd0, a_r} - prod_r[34:0];
    tq     = (trem >= {31'd0, k_r}) ? q_r + 31'd1 : q_r;
    sh8    = 8'sd14 - n_r;
    if (neg_r) begin
      mean_c = (dvd_r > 64'd32768) ? 16'sh8000 : 16'(-dvd_r);
    end else begin
      mean_c = (dvd_r > 64'd32767) ? 16'sh7FFF : 16'(dvd_r);
    end
    mean_use   = (esum_r != '0) ? mean_c : '0;
    d_c        = 34'(slope_r) + 34'(ev_r) - 34'(mean_use);
    d_c_sat_hi = d_c > 34'sd2147483647;
    d_c_sat_lo = d_c < -34'sd2147483648;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_BX;
      S_BX:    state_nxt = S_LOG;
      S_LOG:   state_nxt = S_SPLIT;
      S_SPLIT: begin
        if ($signed(prod_r[61:54]) >= 8'sd16 || $signed(prod_r[61:54]) <= -8'sd50) begin
          state_nxt = S_WMUL;
        end else begin
          state_nxt = S_G;
        end
      end
      S_G:     state_nxt = S_GSH;
      S_GSH:   state_nxt = S_TMUL;
      S_TMUL:  state_nxt = S_TREC;
      S_TREC:  state_nxt = S_TQK;
      S_TQK:   state_nxt = S_TFIX;
      S_TFIX:  state_nxt = (k_r == 4'(TERMS)) ? S_SHIFT : S_TMUL;
      S_SHIFT: state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (!gend_r)           state_nxt = S_OUT;
        else if (es_new == '0) state_nxt = S_SLOPE;
        else                   state_nxt = S_DIV;
      end
      S_DIV:   if (cnt_r == 6'd63) state_nxt = S_SLOPE;
      S_SLOPE: state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      beta_r      <= '0;
      esum_r      <= '0;
      wsum_r      <= '0;
      slope_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= mul_a * mul_b;
      if (cfg_valid) beta_r <= cfg_data;
      if (state_r != S_OUT && out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r    <= in_tdata[15:0];
            ev_r   <= in_tdata[31:16];
            gend_r <= in_tlast;
            send_r <= in_tuser;
            mean_r <= '0;
          end
        end
        S_SPLIT: begin
          n_r <= prod_r[61:54];
          f_r <= prod_r[53:30];
          if ($signed(prod_r[61:54]) >= 8'sd16) e_r <= '1;
          else if ($signed(prod_r[61:54]) <= -8'sd50) e_r <= '0;
        end
        S_GSH: begin
          g_r    <= prod_r[53:24];
          term_r <= ONE_Q30;
          sum_r  <= {1'b0, ONE_Q30};
          k_r    <= 4'd1;
        end
        S_TREC: a_r <= prod_r[60:30];
        S_TQK:  q_r <= prod_r[62:32];
        S_TFIX: begin
          term_r <= tq;
          sum_r  <= sum_r + {1'b0, tq};
          k_r    <= k_r + 4'd1;
        end
        S_SHIFT: begin
          if (n_r == 8'sd15) e_r <= {sum_r[30:0], 1'b0};
          else               e_r <= sum_r >> sh8[5:0];
        end
        S_ACC: begin
          esum_r <= es_new;
          wsum_r <= ws_new;
          neg_r  <= ws_new[WSUM_WIDTH-1];
          dvd_r  <= ws_new[WSUM_WIDTH-1] ? 64'(-ws_new) : 64'(ws_new);
          rem_r  <= '0;
          cnt_r  <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= {1'b0, esum_r}) begin
            rem_r <= rem_sh - {1'b0, esum_r};
            dvd_r <= {dvd_r[WSUM_WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            dvd_r <= {dvd_r[WSUM_WIDTH-2:0], 1'b0};
          end
        end
        S_SLOPE: begin
          mean_r <= mean_use;
          if (d_c_sat_hi)      slope_r <= 32'sh7FFF_FFFF;
          else if (d_c_sat_lo) slope_r <= 32'sh8000_0000;
          else                 slope_r <= d_c[SLOPE_WIDTH-1:0];
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {slope_r, mean_r, gend_r ? esum_r : {SUM_WIDTH{1'b0}}, e_r};
            out_last_r  <= gend_r;
            out_user_r  <= gend_r && send_r;
            if (gend_r) begin
              esum_r <= '0;
              wsum_r <= '0;
              if (send_r) slope_r <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
